/* rtl/core/smf_pkg.sv */
// smf_pkg: shared constants and types of the sliding window median filter.
// No dependencies; every other file of the block imports this package.
package smf_pkg;

  // Parameter defaults for the top level
  localparam int unsigned MaxColsDef = 1024;
  localparam int unsigned MaxRowsDef = 1024;
  localparam int unsigned MaxHalfDef = 2;

  // Fixed field widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned HalfRawW = 2;

  // Register reset values
  localparam int unsigned ColsReset = 1024;
  localparam int unsigned RowsReset = 1024;
  localparam int unsigned HalfReset = 1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCols = 2'd0,
    CfgRows = 2'd1,
    CfgHalf = 2'd2
  } cfg_reg_e;

  // Control that travels with a window through the median pipeline
  typedef struct packed {
    logic interior;
    logic last;
  } res_ctl_t;

endpackage

/* rtl/core/smf_if.sv */
// smf_if: valid/ready channels of the median filter (pixel in, result out,
// configuration write). Depends on smf_pkg for the field widths.
interface smf_pix_if import smf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;
  logic            drain;
  modport source (output valid, pixel_in, drain, input ready);
  modport sink   (input valid, pixel_in, drain, output ready);
endinterface

interface smf_res_if import smf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] filtered_pixel;
  logic            frame_last;
  modport source (output valid, filtered_pixel, frame_last, input ready);
  modport sink   (input valid, filtered_pixel, frame_last, output ready);
endinterface

interface smf_cfg_if import smf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/smf_line_cell.sv */
// smf_line_cell: one raster line of delay, a circular buffer of cols-1 words
// plus a registered read. Depends on smf_pkg.
module smf_line_cell import smf_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              restart_i,
  input  logic                              adv_i,
  input  logic [$clog2(MAX_COLS+1)-1:0]     cols_i,
  input  logic [PixW-1:0]                   din_i,
  output logic [PixW-1:0]                   dout_o
);

  localparam int unsigned Depth = MAX_COLS - 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(MAX_COLS+1);

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rd_q;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   wrap_at;
  logic            bypass;

  // One-pixel rows need no buffer: the read register alone is the delay
  assign bypass  = (cols_i == CW'(1));
  assign wrap_at = cols_i - CW'(2);

  // Advance the pointer round the active part of the buffer
  always_comb begin
    if (ptr_q == wrap_at[AW-1:0]) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (restart_i) begin
      ptr_q <= '0;
    end else if (adv_i && !bypass) begin
      ptr_q <= ptr_d;
    end
  end

  // Read the oldest word, then overwrite it with the new one
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (bypass) begin
        rd_q <= din_i;
      end else begin
        rd_q          <= mem_q[ptr_q];
        mem_q[ptr_q]  <= din_i;
      end
    end
  end

  assign dout_o = rd_q;

endmodule

/* rtl/core/smf_median.sv */
// smf_median: pads the window to full size, ranks every entry and picks the
// median or the centre word. Depends on smf_pkg and smf_res_if.
module smf_median import smf_pkg::*; #(
  parameter int unsigned MAX_HALF = MaxHalfDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  res_ctl_t                           ctl_i,
  input  logic [$clog2(MAX_HALF+1)-1:0]      half_i,
  input  logic [PixW-1:0]                    win_i [(2*MAX_HALF+1)*(2*MAX_HALF+1)],
  smf_res_if.source                          out_o
);

  localparam int unsigned Side = 2*MAX_HALF + 1;
  localparam int unsigned NWin = Side * Side;
  localparam int unsigned RKW  = $clog2(NWin);
  localparam int unsigned HW   = $clog2(MAX_HALF+1);
  localparam int unsigned Mid  = NWin / 2;

  // Stage B: padded window
  logic            vb_q;
  res_ctl_t        ctlb_q;
  logic [PixW-1:0] centerb_q;
  logic [PixW-1:0] pad_d [NWin];
  logic [PixW-1:0] pad_q [NWin];
  logic [PixW-1:0] center_d;
  // Stage C: ranks
  logic            vc_q;
  res_ctl_t        ctlc_q;
  logic [PixW-1:0] centerc_q;
  logic [PixW-1:0] valc_q [NWin];
  logic [RKW-1:0]  rank_q [NWin];
  logic [NWin-1:0] beat [NWin];
  // Stage D: output word
  logic            vd_q;
  logic [PixW-1:0] pix_q;
  logic            last_q;
  logic [PixW-1:0] med;
  logic            rdy_b, rdy_c, rdy_d;
  logic [HW:0]     span;

  assign rdy_d   = !vd_q || out_o.ready;
  assign rdy_c   = !vc_q || rdy_d;
  assign rdy_b   = !vb_q || rdy_c;
  assign ready_o = rdy_b;

  // Fill entries outside the active square with an equal count of black and
  // white, alternating on a checkerboard, so the middle rank is unchanged
  assign span = {half_i, 1'b0};
  always_comb begin
    for (int a = 0; a < Side; a++) begin
      for (int b = 0; b < Side; b++) begin
        if ((HW+1)'(a) <= span && (HW+1)'(b) <= span) begin
          pad_d[a*Side+b] = win_i[a*Side+b];
        end else if (((a + b) % 2) == 0) begin
          pad_d[a*Side+b] = '0;
        end else begin
          pad_d[a*Side+b] = '1;
        end
      end
    end
  end

  // Pick the centre word for border positions
  always_comb begin
    center_d = win_i[0];
    for (int hh = 0; hh <= MAX_HALF; hh++) begin
      if (half_i == HW'(hh)) begin
        center_d = win_i[hh*Side+hh];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && valid_i) begin
      pad_q     <= pad_d;
      centerb_q <= center_d;
      ctlb_q    <= ctl_i;
    end
  end

  // Rank each entry: smaller entries, and equal ones at lower places
  always_comb begin
    for (int i = 0; i < NWin; i++) begin
      for (int j = 0; j < NWin; j++) begin
        beat[i][j] = (j != i) &&
                     ((pad_q[j] < pad_q[i]) || ((pad_q[j] == pad_q[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      for (int i = 0; i < NWin; i++) begin
        rank_q[i] <= RKW'($countones(beat[i]));
        valc_q[i] <= pad_q[i];
      end
      centerc_q <= centerb_q;
      ctlc_q    <= ctlb_q;
    end
  end

  // Select the entry whose rank is the middle one
  always_comb begin
    med = '0;
    for (int i = 0; i < NWin; i++) begin
      if (rank_q[i] == RKW'(Mid)) begin
        med = med | valc_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (rdy_d) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && vc_q) begin
      pix_q  <= ctlc_q.interior ? med : centerc_q;
      last_q <= ctlc_q.last;
    end
  end

  assign out_o.valid          = vd_q;
  assign out_o.filtered_pixel = pix_q;
  assign out_o.frame_last     = last_q;

endmodule

/* rtl/core/sliding_window_median_filter_unit.sv */
// sliding_window_median_filter_unit: top level of the streaming median filter.
// Depends on smf_pkg, smf_if, smf_line_cell and smf_median.
//
// Takes one pixel word per clock in raster order and gives one result word per
// clock once warm, while the output does not stall: the word for the position
// h rows and h columns back, the median of its (2h+1)-square window inside the
// frame and the pixel itself within h of an edge. The first h*cols+h words of a
// frame give no result, so h*cols+h drain words follow each frame. A word passes
// four register stages (window, pad, rank, select): the window stage loads at
// the accepting edge and the pad, rank and select registers follow in turn. The
// rate of one word a clock is set by the line cells, each a buffer of MAX_COLS-1
// words read and written once per accepted word. The line buffers need no
// clearing pass: words written before the current frame are never used. Any
// register write restarts the frame position.
module sliding_window_median_filter_unit import smf_pkg::*; #(
  parameter int unsigned MAX_COLS = MaxColsDef,
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_HALF = MaxHalfDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smf_pix_if.sink   in_i,
  smf_res_if.source out_o,
  smf_cfg_if.sink   cfg_i
);

  localparam int unsigned CW    = $clog2(MAX_COLS+1);
  localparam int unsigned RW    = $clog2(MAX_ROWS+1);
  localparam int unsigned HW    = $clog2(MAX_HALF+1);
  localparam int unsigned DW    = $clog2(MAX_HALF*MAX_COLS + MAX_HALF + 1);
  localparam int unsigned Side  = 2*MAX_HALF + 1;
  localparam int unsigned NLine = 2*MAX_HALF;

  logic [CfgDataW-1:0] cols_raw_q, rows_raw_q;
  logic [HalfRawW-1:0] half_raw_q;
  logic [CW-1:0]       eff_cols;
  logic [RW-1:0]       eff_rows;
  logic [HW-1:0]       eff_half;
  logic [DW-1:0]       delay;
  logic [DW-1:0]       warm_q;
  logic [RW-1:0]       orow_q;
  logic [CW-1:0]       ocol_q;
  logic                restart, acc, warm_done, col_end, row_end, at_last, interior;
  logic                va_q, rdy_a, rdy_b;
  res_ctl_t            ctla_q;
  logic [PixW-1:0]     tap [NLine+1];
  logic [PixW-1:0]     win_q [Side][Side];
  logic [PixW-1:0]     win_flat [Side*Side];
  logic [RW:0]         hr, rext;
  logic [CW:0]         hc, cext;

  // Configuration registers
  assign cfg_i.ready = 1'b1;
  assign restart = cfg_i.valid &&
                   (cfg_i.index == CfgCols || cfg_i.index == CfgRows || cfg_i.index == CfgHalf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_raw_q <= CfgDataW'(ColsReset);
      rows_raw_q <= CfgDataW'(RowsReset);
      half_raw_q <= HalfRawW'(HalfReset);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgCols: cols_raw_q <= cfg_i.data;
        CfgRows: rows_raw_q <= cfg_i.data;
        CfgHalf: half_raw_q <= cfg_i.data[HalfRawW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported range
  always_comb begin
    if (cols_raw_q == '0) begin
      eff_cols = CW'(1);
    end else if (32'(cols_raw_q) > MAX_COLS) begin
      eff_cols = CW'(MAX_COLS);
    end else begin
      eff_cols = CW'(cols_raw_q);
    end
    if (rows_raw_q == '0) begin
      eff_rows = RW'(1);
    end else if (32'(rows_raw_q) > MAX_ROWS) begin
      eff_rows = RW'(MAX_ROWS);
    end else begin
      eff_rows = RW'(rows_raw_q);
    end
    if (32'(half_raw_q) > MAX_HALF) begin
      eff_half = HW'(MAX_HALF);
    end else begin
      eff_half = HW'(half_raw_q);
    end
  end

  assign delay = DW'(eff_half) * DW'(eff_cols) + DW'(eff_half);

  // Position of the result word within the frame
  assign acc       = in_i.valid && rdy_a;
  assign warm_done = (warm_q == delay);
  assign col_end   = (ocol_q == eff_cols - CW'(1));
  assign row_end   = (orow_q == eff_rows - RW'(1));
  assign at_last   = col_end && row_end;

  assign hr   = (RW+1)'(eff_half);
  assign hc   = (CW+1)'(eff_half);
  assign rext = {1'b0, orow_q};
  assign cext = {1'b0, ocol_q};
  assign interior = (rext >= hr) && (rext + hr < {1'b0, eff_rows}) &&
                    (cext >= hc) && (cext + hc < {1'b0, eff_cols});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else if (restart) begin
      warm_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else if (acc) begin
      if (!warm_done) begin
        warm_q <= warm_q + 1'b1;
      end else if (at_last) begin
        warm_q <= '0;
        orow_q <= '0;
        ocol_q <= '0;
      end else if (col_end) begin
        ocol_q <= '0;
        orow_q <= orow_q + 1'b1;
      end else begin
        ocol_q <= ocol_q + 1'b1;
      end
    end
  end

  // Line cells: tap a holds the word a rows back
  assign tap[0] = in_i.drain ? '0 : in_i.pixel_in;

  for (genvar j = 0; j < NLine; j++) begin : g_line
    smf_line_cell #(
      .MAX_COLS (MAX_COLS)
    ) u_line (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .restart_i (restart),
      .adv_i     (acc),
      .cols_i    (eff_cols),
      .din_i     (tap[j]),
      .dout_o    (tap[j+1])
    );
  end

  // Window cells: shift each row by one column per accepted word
  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int a = 0; a < Side; a++) begin
        win_q[a][0] <= tap[a];
        for (int b = 1; b < Side; b++) begin
          win_q[a][b] <= win_q[a][b-1];
        end
      end
    end
  end

  for (genvar a = 0; a < Side; a++) begin : g_row
    for (genvar b = 0; b < Side; b++) begin : g_col
      assign win_flat[a*Side+b] = win_q[a][b];
    end
  end

  // Stage A: hold the result flag for the window just formed
  assign rdy_a      = !va_q || rdy_b;
  assign in_i.ready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= in_i.valid && warm_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ctla_q.interior <= interior;
      ctla_q.last     <= at_last;
    end
  end

  smf_median #(
    .MAX_HALF (MAX_HALF)
  ) u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q),
    .ready_o (rdy_b),
    .ctl_i   (ctla_q),
    .half_i  (eff_half),
    .win_i   (win_flat),
    .out_o   (out_o)
  );

  // Warm-up count never runs past the delay
  a_warm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm_q <= delay)
    else $error("warm-up count beyond delay");

  // Column position stays inside the row
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocol_q < eff_cols)
    else $error("column position outside row");

  // A word taken during warm-up makes no result
  a_warm_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !warm_done && !restart) |=> !va_q)
    else $error("result during warm-up");

  // The last word of a frame restarts the position
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && warm_done && at_last) |=> (warm_q == '0 && orow_q == '0 && ocol_q == '0))
    else $error("position not restarted after frame");

  // An empty window stage always takes a word
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !va_q |-> in_i.ready)
    else $error("stalled with empty window stage");

endmodule

/* verif/sliding_window_median_filter_unit_tb.sv */
// Testbench of sliding_window_median_filter_unit: directed table, extreme settings,
// then random frames, each result checked against a behavioural median predictor.
// Depends on smf_pkg, the smf_if interfaces and the block itself.
`timescale 1ns / 1ps

module sliding_window_median_filter_unit_tb;
  import smf_pkg::*;

  localparam int unsigned HistLen = 2 * MaxHalfDef * MaxColsDef + 2 * MaxHalfDef + 1;
  localparam int unsigned WinMax  = (2 * MaxHalfDef + 1) * (2 * MaxHalfDef + 1);
  localparam int unsigned RndWords = 380;
  // Register index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct {
    logic [PixW-1:0] pix;
    logic            last;
  } median_res_t;

  // One row of the directed table: a register write or a pixel word
  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    logic [PixW-1:0]     px;
    bit                  drn;
    bit                  typed;
    logic [PixW-1:0]     epix;
    bit                  elast;
  } dir_row_t;

  logic clk;
  logic rst_n;

  smf_pix_if pix_if ();
  smf_res_if res_if ();
  smf_cfg_if cfg_if ();

  sliding_window_median_filter_unit uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (pix_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  median_res_t median_q[$];
  int unsigned err_cnt;

  // Predictor state
  logic [PixW-1:0] hist_mem[HistLen];
  int unsigned     hist_wp;
  int unsigned     pos_row;
  int unsigned     pos_col;
  int unsigned     reg_cols;
  int unsigned     reg_rows;
  int unsigned     reg_half;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit of the run
  initial begin
    #5ms;
    $display("sliding_window_median_filter_unit_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [PixW-1:0] hist_back(input int unsigned d);
    return hist_mem[(hist_wp + HistLen - (d % HistLen)) % HistLen];
  endfunction

  function automatic void cfg_apply(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      CfgCols: reg_cols = 32'(val);
      CfgRows: reg_rows = 32'(val);
      CfgHalf: reg_half = 32'(val[HalfRawW-1:0]);
      default: return;
    endcase
    pos_row = 0;
    pos_col = 0;
  endfunction

  // Advance the filter by one word; returns 1 when a result is due
  function automatic bit median_predict(input logic [PixW-1:0] px_in, input bit drn,
                                        output median_res_t res);
    int unsigned cols, rows, h, dly, area, k, o, r, c, side, n, idx, back;
    logic [PixW-1:0] win[WinMax];
    logic [PixW-1:0] v;
    int j;
    cols = (reg_cols < 1) ? 1 : (reg_cols > MaxColsDef) ? MaxColsDef : reg_cols;
    rows = (reg_rows < 1) ? 1 : (reg_rows > MaxRowsDef) ? MaxRowsDef : reg_rows;
    h    = (reg_half > MaxHalfDef) ? MaxHalfDef : reg_half;
    dly  = h * cols + h;
    area = rows * cols;
    res  = '{pix: '0, last: 1'b0};
    hist_wp = (hist_wp + 1) % HistLen;
    hist_mem[hist_wp] = drn ? '0 : px_in;
    k = pos_row * cols + pos_col;
    pos_col++;
    if (pos_col >= cols) begin
      pos_col = 0;
      pos_row++;
    end
    if (k < dly) return 1'b0;
    o = k - dly;
    if (o >= area) begin
      pos_row = 0;
      pos_col = 0;
      return 1'b0;
    end
    r = o / cols;
    c = o % cols;
    res.pix = hist_back(dly);
    if (r >= h && r + h < rows && c >= h && c + h < cols) begin
      side = 2 * h + 1;
      n    = side * side;
      idx  = 0;
      for (int dr = 0; dr < side; dr++) begin
        for (int dc = 0; dc < side; dc++) begin
          back = 2 * dly - dr * cols - dc;
          win[idx++] = hist_back(back);
        end
      end
      // Insertion sort, then take the middle
      for (int i = 1; i < n; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      res.pix = win[n/2];
    end
    res.last = (o == area - 1);
    if (res.last) begin
      pos_row = 0;
      pos_col = 0;
    end
    return 1'b1;
  endfunction

  // Receiver stall pattern: free running, coin toss, or mostly stalled
  int unsigned rdy_mode;
  int unsigned rdy_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      rdy_left = 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 2);
        rdy_left = $urandom_range(4, 64);
      end
      rdy_left--;
      case (rdy_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= 1'($urandom_range(0, 1));
        default: res_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    median_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (median_q.size() == 0) begin
        report_mismatch("unexpected word, pixel", res_if.filtered_pixel, -1);
      end else begin
        want = median_q.pop_front();
        if (res_if.filtered_pixel !== want.pix)
          report_mismatch("filtered_pixel", res_if.filtered_pixel, want.pix);
        if (res_if.frame_last !== want.last)
          report_mismatch("frame_last", res_if.frame_last, want.last);
      end
    end
  end

  int unsigned burst_left;

  // Send one pixel word, with gaps between bursts; typed rows give their own result
  task automatic send_word(input logic [PixW-1:0] px, input bit drn,
                           input bit typed = 0, input median_res_t tres = '{'0, 1'b0});
    int unsigned gap;
    median_res_t res;
    bit due;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= px;
    pix_if.drain    <= drn;
    do @(posedge clk); while (!pix_if.ready);
    due = median_predict(px, drn, res);
    if (typed) median_q.insert(median_q.size(), tres);
    else if (due) median_q.insert(median_q.size(), res);
    burst_left--;
  endtask

  // Drop valid and hold until every expected word has come, plus pipeline slack
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_apply(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned cols, input int unsigned rows,
                           input int unsigned half);
    wait_idle();
    write_reg(CfgCols, CfgDataW'(cols));
    write_reg(CfgRows, CfgDataW'(rows));
    write_reg(CfgHalf, CfgDataW'(half));
  endtask

  // Whole frame of random pixels followed by its drain words
  task automatic send_frame();
    int unsigned cols, rows, h, total;
    cols  = (reg_cols < 1) ? 1 : (reg_cols > MaxColsDef) ? MaxColsDef : reg_cols;
    rows  = (reg_rows < 1) ? 1 : (reg_rows > MaxRowsDef) ? MaxRowsDef : reg_rows;
    h     = (reg_half > MaxHalfDef) ? MaxHalfDef : reg_half;
    total = rows * cols + h * cols + h;
    for (int unsigned s = 0; s < total; s++)
      send_word(PixW'($urandom_range(0, 255)), s >= rows * cols);
  endtask

  dir_row_t dir_tab[$];

  initial begin
    int unsigned rnd_cnt, cols, rows, half, area, dly, slot_end, nfr;
    bit pressed, drn;
    logic [PixW-1:0] px;
    err_cnt    = 0;
    burst_left = 0;
    pressed    = 1'b0;
    hist_wp    = 0;
    pos_row    = 0;
    pos_col    = 0;
    reg_cols   = ColsReset;
    reg_rows   = RowsReset;
    reg_half   = HalfReset;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    rst_n           = 1'b0;
    pix_if.valid    = 1'b0;
    pix_if.pixel_in = '0;
    pix_if.drain    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CfgCols;
    cfg_if.data     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 1x1 window passes pixels, drain inside the frame gives zero,
    // then a 3x3 frame with a median centre and a pixel in a drain slot
    dir_tab = '{
      '{1, CfgHalf, 11'd0, 8'h00, 0, 0, 8'h00, 0},
      '{1, CfgCols, 11'd3, 8'h00, 0, 0, 8'h00, 0},
      '{1, CfgRows, 11'd2, 8'h00, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 0, 1, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'hFF, 0, 1, 8'hFF, 0},
      '{0, CfgCols, 11'd0, 8'h80, 0, 1, 8'h80, 0},
      '{0, CfgCols, 11'd0, 8'h01, 0, 1, 8'h01, 0},
      '{0, CfgCols, 11'd0, 8'hAA, 1, 1, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h7F, 0, 1, 8'h7F, 1},
      '{1, CfgRows, 11'd3, 8'h00, 0, 0, 8'h00, 0},
      '{1, CfgHalf, 11'd1, 8'h00, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'hFF, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'hFF, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h10, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'hFF, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'hFF, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 1, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h55, 0, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 1, 0, 8'h00, 0},
      '{0, CfgCols, 11'd0, 8'h00, 1, 0, 8'h00, 0}
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].px, dir_tab[i].drn, dir_tab[i].typed,
                  '{dir_tab[i].epix, dir_tab[i].elast});
      end
    end

    // Extremes: clamped sizes, an ignored index, a half size above the largest
    set_frame(0, 0, 0);
    wait_idle();
    write_reg(CfgUnused, 11'h7FF);
    send_frame();
    set_frame(11'h7FF, 1, 0);
    send_frame();
    set_frame(5, 4, 3);
    send_frame();

    // Random frames, mostly well formed, some broken
    rnd_cnt = 0;
    while (rnd_cnt < RndWords) begin
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      rows = $urandom_range(1, 8);
      half = $urandom_range(0, 3);
      set_frame(cols, rows, half);
      if ($urandom_range(0, 7) == 0) begin
        wait_idle();
        write_reg(CfgUnused, CfgDataW'($urandom_range(0, 2047)));
      end
      half = (half > MaxHalfDef) ? MaxHalfDef : half;
      area = rows * cols;
      dly  = half * cols + half;
      nfr  = $urandom_range(1, 3);
      for (int unsigned f = 0; f < nfr && rnd_cnt < RndWords; f++) begin
        slot_end = area + dly;
        if ($urandom_range(0, 9) == 0) slot_end = $urandom_range(1, slot_end);
        for (int unsigned s = 0; s < slot_end && rnd_cnt < RndWords; s++) begin
          px = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                           : PixW'($urandom_range(0, 255));
          drn = (s >= area) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 30) == 0);
          // Hold the sender once until the pipe has emptied
          if (!pressed && rnd_cnt > 100 && s == area / 2) begin
            wait_idle();
            pressed = 1'b1;
          end
          send_word(px, drn);
          rnd_cnt++;
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("sliding_window_median_filter_unit_tb OK");
    end else begin
      $display("sliding_window_median_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
